FILE: hw/rtl/segi_pkg.sv
// Shared types and constants for the segment intersection pipeline.
`default_nettype none

package segi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int NUM_COORDS      = 8;
    localparam int TOL_W           = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd512;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_CROSS   = 2'd1,
        KIND_OVERLAP = 2'd2,
        KIND_POINT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic  vld;
        t_kind kind;
    } t_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/segment_intersection.sv
// Top level: stream ports, tolerance register, pipeline and output skid stage.
//
// Tests two 2-D segments (signed fixed point, low COORD_WIDTH bits of each
// field used) for a shared point and returns one result per request.
// Input channel s_*: one request per accepted beat, eight coordinates in s_tdata.
// Output channel m_*: m_tdata carries the meeting point, m_tuser the hit flag
// and the kind of meeting (none, crossing, collinear overlap, point input).
// Config channel: i_cfg_valid/i_cfg_data write the 16-bit tolerance;
// always ready, write only while no request is in flight.
// Stages: 6 product/decision stages, 2 scaling stages, one quotient bit per
// stage over COORD_WIDTH + 1 stages, one add stage and the output register.
// Throughput: one request per cycle while the skid register is empty; every
// stage moves on a common enable.
// When m_tready is low, the output register holds and one more result lands
// in the skid register; only then does s_tready drop and the pipe freeze.
// Reset (synchronous, active low) empties the pipe and the output and sets
// the tolerance to 512.
`default_nettype none

module segment_intersection #(
    parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y (32 bits each)
    input  wire logic [255:0]           s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // meet_x [31:0], meet_y [63:32]
    output logic [63:0]                 m_tdata,
    // hit [0], meet_kind [2:1]
    output logic [2:0]                  m_tuser,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [segi_pkg::TOL_W-1:0] i_cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int NW = 2 * DW;
    localparam int FW = segi_pkg::FIELD_W;

    logic [segi_pkg::TOL_W-1:0] r_tol;
    logic                        w_en;
    logic [segi_pkg::NUM_COORDS*CW-1:0] w_coord;

    segi_pkg::t_ctrl      w_f_ctrl, w_d_ctrl;
    logic [NW-1:0]        w_num, w_dnm;
    logic signed [DW-1:0] w_rx, w_ry;
    logic signed [CW-1:0] w_bx, w_by, w_x, w_y;

    logic        w_hit;
    logic [63:0] w_data;
    logic [2:0]  w_user;
    logic        w_push, w_take;

    logic        r_out_vld, r_skid_vld;
    logic [63:0] r_out_data, r_skid_data;
    logic [2:0]  r_out_user, r_skid_user;

    for (genvar k = 0; k < segi_pkg::NUM_COORDS; k++) begin : g_coord
        assign w_coord[k*CW +: CW] = s_tdata[k*FW +: CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= segi_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipe runs whenever the skid register is free
    assign w_en     = !r_skid_vld;
    assign s_tready = w_en;

    segi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_tvalid),
        .i_coord (w_coord),
        .i_tol   (r_tol),
        .o_ctrl  (w_f_ctrl),
        .o_num   (w_num),
        .o_dnm   (w_dnm),
        .o_rx    (w_rx),
        .o_ry    (w_ry),
        .o_bx    (w_bx),
        .o_by    (w_by)
    );

    segi_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctrl  (w_f_ctrl),
        .i_num   (w_num),
        .i_dnm   (w_dnm),
        .i_rx    (w_rx),
        .i_ry    (w_ry),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .o_ctrl  (w_d_ctrl),
        .o_x     (w_x),
        .o_y     (w_y)
    );

    // zero the point when there is no hit
    assign w_hit  = w_d_ctrl.kind != segi_pkg::KIND_NONE;
    assign w_data = w_hit ? {FW'(w_y), FW'(w_x)} : '0;
    assign w_user = {w_d_ctrl.kind, w_hit};

    assign w_push = w_en && w_d_ctrl.vld;
    assign w_take = r_out_vld && m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_take) begin
                r_out_data <= w_data;
                r_out_user <= w_user;
            end else begin
                r_skid_data <= w_data;
                r_skid_user <= w_user;
            end
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_user;

endmodule

`default_nettype wire

FILE: hw/rtl/segi_front.sv
// Front pipeline: differences, cross and dot products, tolerance tests, case selection.
`default_nettype none

module segi_front #(
    parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_en,
    input  wire logic                                    i_valid,
    input  wire logic [segi_pkg::NUM_COORDS*COORD_WIDTH-1:0] i_coord,
    input  wire logic [segi_pkg::TOL_W-1:0]              i_tol,
    output segi_pkg::t_ctrl                              o_ctrl,
    output logic [2*COORD_WIDTH+1:0]                     o_num,
    output logic [2*COORD_WIDTH+1:0]                     o_dnm,
    output logic signed [COORD_WIDTH:0]                  o_rx,
    output logic signed [COORD_WIDTH:0]                  o_ry,
    output logic signed [COORD_WIDTH-1:0]                o_bx,
    output logic signed [COORD_WIDTH-1:0]                o_by
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int NS = 6;

    localparam int P1X = 0;
    localparam int P1Y = 1;
    localparam int P2X = 2;
    localparam int P2Y = 3;
    localparam int P3X = 4;
    localparam int P3Y = 5;
    localparam int P4X = 6;
    localparam int P4Y = 7;

    function automatic logic betw(input logic signed [CW-1:0] v,
                                  input logic signed [CW-1:0] a,
                                  input logic signed [CW-1:0] b);
        betw = (v <= b && a <= v) || (v <= a && b <= v);
    endfunction

    function automatic logic big(input logic signed [XW-1:0] v,
                                 input logic [segi_pkg::TOL_W-1:0] tol);
        logic [XW-1:0] m;
        m   = v[XW-1] ? XW'(-v) : XW'(v);
        big = m > {{(XW-segi_pkg::TOL_W){1'b0}}, tol};
    endfunction

    logic [NS-1:0] r_vld;

    // stage 1: registered coordinates
    logic signed [CW-1:0] r1_c [segi_pkg::NUM_COORDS];

    // stage 2: differences and point flags
    logic signed [DW-1:0] r2_rx, r2_ry, r2_sx, r2_sy, r2_qx, r2_qy;
    logic signed [DW-1:0] r2_wx, r2_wy, r2_vx, r2_vy;
    logic                 r2_rz, r2_sz, r2_qz, r2_rxne, r2_sxne;
    logic                 r2_bax, r2_bay, r2_bbx, r2_bby;
    logic signed [CW-1:0] r2_p1x, r2_p1y, r2_p3x, r2_p3y;

    // stage 3: products
    logic signed [PW-1:0] r3_den1, r3_den2, r3_tn1, r3_tn2, r3_un1, r3_un2;
    logic signed [PW-1:0] r3_rr1, r3_rr2, r3_a1, r3_a2, r3_b1, r3_b2, r3_pc1, r3_pc2;
    logic signed [DW-1:0] r3_rx, r3_ry;
    logic                 r3_rz, r3_sz, r3_qz, r3_rxne, r3_sxne;
    logic                 r3_bax, r3_bay, r3_bbx, r3_bby;
    logic signed [CW-1:0] r3_p1x, r3_p1y, r3_p3x, r3_p3y;
    logic signed [DW-1:0] w_pcx, w_pcy;

    // stage 4: sums
    logic signed [XW-1:0] r4_den, r4_tn, r4_un, r4_rr, r4_a, r4_b, r4_pc;
    logic signed [DW-1:0] r4_rx, r4_ry;
    logic                 r4_rz, r4_sz, r4_qz, r4_rxne, r4_sxne;
    logic                 r4_bax, r4_bay, r4_bbx, r4_bby;
    logic signed [CW-1:0] r4_p1x, r4_p1y, r4_p3x, r4_p3y;

    // stage 5: tolerance tests, sign normalization, ordering
    logic signed [XW-1:0] r5_den, r5_tn, r5_un, r5_rr, r5_lo, r5_hi;
    logic                 r5_den_big, r5_un_big, r5_pc_big;
    logic signed [DW-1:0] r5_rx, r5_ry;
    logic                 r5_rz, r5_sz, r5_qz, r5_rxne, r5_sxne;
    logic                 r5_bax, r5_bay, r5_bbx, r5_bby;
    logic signed [CW-1:0] r5_p1x, r5_p1y, r5_p3x, r5_p3y;

    // stage 6: case decision
    segi_pkg::t_kind      r6_kind, n6_kind;
    logic [PW-1:0]        r6_num, r6_dnm, n6_num, n6_dnm;
    logic signed [DW-1:0] r6_rx, r6_ry;
    logic signed [CW-1:0] r6_bx, r6_by, n6_bx, n6_by;
    logic                 w_cross_ok, w_coll_ok, w_hit_a, w_hit_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    assign w_pcx = r2_rz ? r2_wx : r2_vx;
    assign w_pcy = r2_rz ? r2_wy : r2_vy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < segi_pkg::NUM_COORDS; k++) begin
                r1_c[k] <= i_coord[k*CW +: CW];
            end

            r2_rx   <= DW'(r1_c[P2X]) - DW'(r1_c[P1X]);
            r2_ry   <= DW'(r1_c[P2Y]) - DW'(r1_c[P1Y]);
            r2_sx   <= DW'(r1_c[P4X]) - DW'(r1_c[P3X]);
            r2_sy   <= DW'(r1_c[P4Y]) - DW'(r1_c[P3Y]);
            r2_qx   <= DW'(r1_c[P3X]) - DW'(r1_c[P1X]);
            r2_qy   <= DW'(r1_c[P3Y]) - DW'(r1_c[P1Y]);
            r2_wx   <= DW'(r1_c[P4X]) - DW'(r1_c[P1X]);
            r2_wy   <= DW'(r1_c[P4Y]) - DW'(r1_c[P1Y]);
            r2_vx   <= DW'(r1_c[P2X]) - DW'(r1_c[P3X]);
            r2_vy   <= DW'(r1_c[P2Y]) - DW'(r1_c[P3Y]);
            r2_rz   <= (r1_c[P1X] == r1_c[P2X]) && (r1_c[P1Y] == r1_c[P2Y]);
            r2_sz   <= (r1_c[P3X] == r1_c[P4X]) && (r1_c[P3Y] == r1_c[P4Y]);
            r2_qz   <= (r1_c[P1X] == r1_c[P3X]) && (r1_c[P1Y] == r1_c[P3Y]);
            r2_rxne <= r1_c[P1X] != r1_c[P2X];
            r2_sxne <= r1_c[P3X] != r1_c[P4X];
            r2_bax  <= betw(r1_c[P1X], r1_c[P3X], r1_c[P4X]);
            r2_bay  <= betw(r1_c[P1Y], r1_c[P3Y], r1_c[P4Y]);
            r2_bbx  <= betw(r1_c[P3X], r1_c[P1X], r1_c[P2X]);
            r2_bby  <= betw(r1_c[P3Y], r1_c[P1Y], r1_c[P2Y]);
            r2_p1x  <= r1_c[P1X];
            r2_p1y  <= r1_c[P1Y];
            r2_p3x  <= r1_c[P3X];
            r2_p3y  <= r1_c[P3Y];

            r3_den1 <= PW'(r2_rx) * PW'(r2_sy);
            r3_den2 <= PW'(r2_ry) * PW'(r2_sx);
            r3_tn1  <= PW'(r2_qx) * PW'(r2_sy);
            r3_tn2  <= PW'(r2_qy) * PW'(r2_sx);
            r3_un1  <= PW'(r2_qx) * PW'(r2_ry);
            r3_un2  <= PW'(r2_qy) * PW'(r2_rx);
            r3_rr1  <= PW'(r2_rx) * PW'(r2_rx);
            r3_rr2  <= PW'(r2_ry) * PW'(r2_ry);
            r3_a1   <= PW'(r2_qx) * PW'(r2_rx);
            r3_a2   <= PW'(r2_qy) * PW'(r2_ry);
            r3_b1   <= PW'(r2_wx) * PW'(r2_rx);
            r3_b2   <= PW'(r2_wy) * PW'(r2_ry);
            // point test: (q x w) for a point first segment, (q x v) otherwise
            r3_pc1  <= PW'(r2_qx) * PW'(w_pcy);
            r3_pc2  <= PW'(r2_qy) * PW'(w_pcx);
            r3_rx   <= r2_rx;
            r3_ry   <= r2_ry;
            r3_rz   <= r2_rz;
            r3_sz   <= r2_sz;
            r3_qz   <= r2_qz;
            r3_rxne <= r2_rxne;
            r3_sxne <= r2_sxne;
            r3_bax  <= r2_bax;
            r3_bay  <= r2_bay;
            r3_bbx  <= r2_bbx;
            r3_bby  <= r2_bby;
            r3_p1x  <= r2_p1x;
            r3_p1y  <= r2_p1y;
            r3_p3x  <= r2_p3x;
            r3_p3y  <= r2_p3y;

            r4_den  <= XW'(r3_den1) - XW'(r3_den2);
            r4_tn   <= XW'(r3_tn1) - XW'(r3_tn2);
            r4_un   <= XW'(r3_un1) - XW'(r3_un2);
            r4_rr   <= XW'(r3_rr1) + XW'(r3_rr2);
            r4_a    <= XW'(r3_a1) + XW'(r3_a2);
            r4_b    <= XW'(r3_b1) + XW'(r3_b2);
            r4_pc   <= XW'(r3_pc1) - XW'(r3_pc2);
            r4_rx   <= r3_rx;
            r4_ry   <= r3_ry;
            r4_rz   <= r3_rz;
            r4_sz   <= r3_sz;
            r4_qz   <= r3_qz;
            r4_rxne <= r3_rxne;
            r4_sxne <= r3_sxne;
            r4_bax  <= r3_bax;
            r4_bay  <= r3_bay;
            r4_bbx  <= r3_bbx;
            r4_bby  <= r3_bby;
            r4_p1x  <= r3_p1x;
            r4_p1y  <= r3_p1y;
            r4_p3x  <= r3_p3x;
            r4_p3y  <= r3_p3y;

            r5_den_big <= big(r4_den, i_tol);
            // collinearity uses |q x r|, which equals |un|
            r5_un_big  <= big(r4_un, i_tol);
            r5_pc_big  <= big(r4_pc, i_tol);
            r5_den     <= r4_den[XW-1] ? -r4_den : r4_den;
            r5_tn      <= r4_den[XW-1] ? -r4_tn  : r4_tn;
            r5_un      <= r4_den[XW-1] ? -r4_un  : r4_un;
            r5_rr      <= r4_rr;
            r5_lo      <= (r4_a > r4_b) ? r4_b : r4_a;
            r5_hi      <= (r4_a > r4_b) ? r4_a : r4_b;
            r5_rx      <= r4_rx;
            r5_ry      <= r4_ry;
            r5_rz      <= r4_rz;
            r5_sz      <= r4_sz;
            r5_qz      <= r4_qz;
            r5_rxne    <= r4_rxne;
            r5_sxne    <= r4_sxne;
            r5_bax     <= r4_bax;
            r5_bay     <= r4_bay;
            r5_bbx     <= r4_bbx;
            r5_bby     <= r4_bby;
            r5_p1x     <= r4_p1x;
            r5_p1y     <= r4_p1y;
            r5_p3x     <= r4_p3x;
            r5_p3y     <= r4_p3y;

            r6_kind <= n6_kind;
            r6_num  <= n6_num;
            r6_dnm  <= n6_dnm;
            r6_rx   <= r5_rx;
            r6_ry   <= r5_ry;
            r6_bx   <= n6_bx;
            r6_by   <= n6_by;
        end
    end

    assign w_cross_ok = !r5_tn[XW-1] && !r5_un[XW-1] && (r5_tn <= r5_den) && (r5_un <= r5_den);
    assign w_coll_ok  = (r5_lo <= r5_rr) && !r5_hi[XW-1];
    assign w_hit_a    = r5_sz ? r5_qz : (!r5_pc_big && (r5_sxne ? r5_bax : r5_bay));
    assign w_hit_b    = !r5_pc_big && (r5_rxne ? r5_bbx : r5_bby);

    // point cases pass through the divider with a zero offset
    always_comb begin
        n6_kind = segi_pkg::KIND_NONE;
        n6_num  = '0;
        n6_dnm  = PW'(1);
        n6_bx   = r5_p1x;
        n6_by   = r5_p1y;
        if (r5_rz) begin
            if (w_hit_a) begin
                n6_kind = segi_pkg::KIND_POINT;
            end
        end else if (r5_sz) begin
            n6_bx = r5_p3x;
            n6_by = r5_p3y;
            if (w_hit_b) begin
                n6_kind = segi_pkg::KIND_POINT;
            end
        end else if (r5_den_big) begin
            if (w_cross_ok) begin
                n6_kind = segi_pkg::KIND_CROSS;
                n6_num  = r5_tn[PW-1:0];
                n6_dnm  = r5_den[PW-1:0];
            end
        end else if (!r5_un_big) begin
            if (w_coll_ok) begin
                n6_kind = segi_pkg::KIND_OVERLAP;
                n6_num  = r5_lo[XW-1] ? '0 : r5_lo[PW-1:0];
                n6_dnm  = r5_rr[PW-1:0];
            end
        end
    end

    assign o_ctrl.vld  = r_vld[NS-1];
    assign o_ctrl.kind = r6_kind;
    assign o_num       = r6_num;
    assign o_dnm       = r6_dnm;
    assign o_rx        = r6_rx;
    assign o_ry        = r6_ry;
    assign o_bx        = r6_bx;
    assign o_by        = r6_by;

endmodule

`default_nettype wire

FILE: hw/rtl/segi_div.sv
// Offset pipeline: scale by the direction, then one quotient bit per stage, then add to base.
`default_nettype none

module segi_div #(
    parameter int COORD_WIDTH = segi_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  segi_pkg::t_ctrl                  i_ctrl,
    input  wire logic [2*COORD_WIDTH+1:0]    i_num,
    input  wire logic [2*COORD_WIDTH+1:0]    i_dnm,
    input  wire logic signed [COORD_WIDTH:0] i_rx,
    input  wire logic signed [COORD_WIDTH:0] i_ry,
    input  wire logic signed [COORD_WIDTH-1:0] i_bx,
    input  wire logic signed [COORD_WIDTH-1:0] i_by,
    output segi_pkg::t_ctrl                  o_ctrl,
    output logic signed [COORD_WIDTH-1:0]    o_x,
    output logic signed [COORD_WIDTH-1:0]    o_y
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int NW = 2 * DW;
    localparam int RW = 3 * DW + 1;
    localparam int QB = DW;
    localparam int NS = QB + 3;

    logic [NS-1:0] r_vld;

    logic signed [DW-1:0] w_d [2];
    logic signed [CW-1:0] w_b [2];

    // scaling stage
    logic [NW-1:0]        r_m_pl [2];
    logic [NW-1:0]        r_m_ph [2];
    logic                 r_m_sg [2];
    logic signed [CW-1:0] r_m_bs [2];
    logic [NW-1:0]        r_m_dnm;
    segi_pkg::t_kind      r_m_kind;

    // divide stages, index = quotient bits done
    logic [RW-1:0]        r_rem [2][QB+1];
    logic [QB-1:0]        r_q   [2][QB+1];
    logic                 r_sg  [2][QB+1];
    logic signed [CW-1:0] r_bs  [2][QB+1];
    logic [NW:0]          r_d2  [QB+1];
    segi_pkg::t_kind      r_kind [QB+1];

    // result stage
    logic signed [CW-1:0] r_f_c [2];
    segi_pkg::t_kind      r_f_kind;

    assign w_d[0] = i_rx;
    assign w_d[1] = i_ry;
    assign w_b[0] = i_bx;
    assign w_b[1] = i_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_ctrl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_dnm  <= i_dnm;
            r_m_kind <= i_ctrl.kind;
            r_d2[0]  <= {r_m_dnm, 1'b0};
            r_kind[0] <= r_m_kind;
            r_f_kind <= r_kind[QB];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [DW-1:0] w_mag;
        logic [RW-2:0] w_p;

        assign w_mag = w_d[l][DW-1] ? DW'(-w_d[l]) : DW'(w_d[l]);
        assign w_p   = (RW-1)'(r_m_pl[l]) + ((RW-1)'(r_m_ph[l]) << DW);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // two partial products of num * |d|
                r_m_pl[l] <= NW'(i_num[DW-1:0]) * NW'(w_mag);
                r_m_ph[l] <= NW'(i_num[NW-1:DW]) * NW'(w_mag);
                r_m_sg[l] <= w_d[l][DW-1];
                r_m_bs[l] <= w_b[l];

                // round to nearest: (2*num*|d| + den) / (2*den)
                r_rem[l][0] <= {w_p, 1'b0} + RW'(r_m_dnm);
                r_q[l][0]   <= '0;
                r_sg[l][0]  <= r_m_sg[l];
                r_bs[l][0]  <= r_m_bs[l];

                r_f_c[l] <= r_sg[l][QB] ? r_bs[l][QB] - CW'(r_q[l][QB])
                                        : r_bs[l][QB] + CW'(r_q[l][QB]);
            end
        end

        for (genvar j = 0; j < QB; j++) begin : g_step
            logic [RW:0]   w_trial;
            logic [QB-1:0] n_q;

            assign w_trial = {1'b0, r_rem[l][j]} - ((RW+1)'(r_d2[j]) << (QB-1-j));

            always_comb begin
                n_q = r_q[l][j];
                n_q[QB-1-j] = !w_trial[RW];
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[l][j+1] <= w_trial[RW] ? r_rem[l][j] : w_trial[RW-1:0];
                    r_q[l][j+1]   <= n_q;
                    r_sg[l][j+1]  <= r_sg[l][j];
                    r_bs[l][j+1]  <= r_bs[l][j];
                end
            end
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d2[j+1]   <= r_d2[j];
                r_kind[j+1] <= r_kind[j];
            end
        end
    end

    assign o_ctrl.vld  = r_vld[NS-1];
    assign o_ctrl.kind = r_f_kind;
    assign o_x         = r_f_c[0];
    assign o_y         = r_f_c[1];

endmodule

`default_nettype wire

FILE: hw/rtl/segi_checker.sv
// Port-level checks for the segment intersection block, bound to the top level.
`default_nettype none

module segi_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tuser[0] == (m_tuser[2:1] != segi_pkg::KIND_NONE))
        else $error("hit flag disagrees with meeting kind");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
        else $error("meeting point not zero on a miss");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result presented right after reset");

endmodule

bind segment_intersection segi_checker u_segi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/segment_intersection_test.sv
// Self-checking testbench for the segment intersection pipeline.
`default_nettype none

module segment_intersection_test;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic            hit;
        segi_pkg::t_kind kind;
        logic [31:0]     x;
        logic [31:0]     y;
    } t_meet;

    typedef struct {
        logic [31:0] c [8];
        logic        checked;
        t_meet       res;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [15:0]  i_cfg_data;

    segment_intersection u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    localparam int LATENCY = 43;
    localparam int LIMIT   = 400000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    t_meet    pending_meets[$];
    t_wide    tol;
    int       errors;
    int       cycles;
    int       results_seen;
    logic     stim_done;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, results_seen);
        errors++;
    endtask

    function automatic t_wide cross2(t_wide ax, t_wide ay, t_wide bx, t_wide by);
        return ax * by - ay * bx;
    endfunction

    function automatic logic above_tol(t_wide v);
        t_wide a;
        a = v < 0 ? -v : v;
        return a > tol;
    endfunction

    function automatic logic between(t_wide v, t_wide a, t_wide b);
        return (v <= b && a <= v) || (v <= a && b <= v);
    endfunction

    function automatic logic on_seg(t_wide px, t_wide py, t_wide ax, t_wide ay,
                                    t_wide bx, t_wide by);
        if (ax == bx && ay == by) return px == ax && py == ay;
        if (above_tol(cross2(ax - px, ay - py, bx - px, by - py))) return 1'b0;
        if (ax != bx) return between(px, ax, bx);
        return between(py, ay, by);
    endfunction

    // base + round(num * d / den), ties away from zero; num >= 0, den > 0
    function automatic logic [31:0] walk(t_wide base, t_wide num, t_wide den, t_wide d);
        logic [127:0] prod;
        logic [127:0] q;
        t_wide        off;
        prod = 128'(num) * 128'(d < 0 ? -d : d);
        q    = ((prod << 1) + 128'(den)) / (128'(den) << 1);
        off  = t_wide'({88'd0, q[39:0]});
        return d < 0 ? 32'(base - off) : 32'(base + off);
    endfunction

    function automatic t_meet predict_meet(logic [31:0] c [8]);
        t_wide p1x, p1y, p2x, p2y, p3x, p3y, p4x, p4y;
        t_wide rx, ry, sx, sy, qx, qy, den, tn, un, rr, a, b, tmp;
        t_meet m;
        p1x = $signed(c[0]); p1y = $signed(c[1]); p2x = $signed(c[2]); p2y = $signed(c[3]);
        p3x = $signed(c[4]); p3y = $signed(c[5]); p4x = $signed(c[6]); p4y = $signed(c[7]);
        rx = p2x - p1x; ry = p2y - p1y; sx = p4x - p3x; sy = p4y - p3y;
        qx = p3x - p1x; qy = p3y - p1y;
        m.kind = segi_pkg::KIND_NONE; m.x = '0; m.y = '0;
        if (rx == 0 && ry == 0) begin
            if (on_seg(p1x, p1y, p3x, p3y, p4x, p4y)) begin
                m.kind = segi_pkg::KIND_POINT; m.x = 32'(p1x); m.y = 32'(p1y);
            end
        end else if (sx == 0 && sy == 0) begin
            if (on_seg(p3x, p3y, p1x, p1y, p2x, p2y)) begin
                m.kind = segi_pkg::KIND_POINT; m.x = 32'(p3x); m.y = 32'(p3y);
            end
        end else begin
            den = cross2(rx, ry, sx, sy);
            if (above_tol(den)) begin
                tn = cross2(qx, qy, sx, sy);
                un = cross2(qx, qy, rx, ry);
                if (den < 0) begin
                    den = -den; tn = -tn; un = -un;
                end
                if (tn >= 0 && un >= 0 && tn <= den && un <= den) begin
                    m.kind = segi_pkg::KIND_CROSS;
                    m.x = walk(p1x, tn, den, rx);
                    m.y = walk(p1y, tn, den, ry);
                end
            end else if (!above_tol(cross2(qx, qy, rx, ry))) begin
                rr = rx * rx + ry * ry;
                a  = qx * rx + qy * ry;
                b  = (p4x - p1x) * rx + (p4y - p1y) * ry;
                if (a > b) begin
                    tmp = a; a = b; b = tmp;
                end
                if (a <= rr && b >= 0) begin
                    tn = a < 0 ? t_wide'(0) : a;
                    m.kind = segi_pkg::KIND_OVERLAP;
                    m.x = walk(p1x, tn, rr, rx);
                    m.y = walk(p1y, tn, rr, ry);
                end
            end
        end
        m.hit = m.kind != segi_pkg::KIND_NONE;
        return m;
    endfunction

    // Drive one request and hold it until accepted.
    task automatic send_request(input logic [31:0] c [8], input logic checked,
                                input t_meet want);
        t_meet m;
        m = checked ? want : predict_meet(c);
        for (int i = 0; i < 8; i++) s_tdata[32*i +: 32] <= c[i];
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        pending_meets.push_back(m);
        @(negedge i_clk);
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        while (pending_meets.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tol = t_wide'(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] small_coord();
        return 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
    endfunction

    function automatic t_row random_row();
        t_row  r;
        int    mode;
        logic [31:0] bx, by, dx, dy;
        int    k0, k1;
        r.checked = 1'b0;
        r.res = '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0};
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++) r.c[i] = small_coord();
        case (mode)
            0, 1: begin
                for (int i = 0; i < 8; i++) r.c[i] = $urandom();
            end
            2, 3: begin
                // collinear: all four points on one line through (bx,by)
                bx = small_coord(); by = small_coord();
                dx = 32'($signed($urandom_range(0, 512)) - 256) << $urandom_range(0, 8);
                dy = 32'($signed($urandom_range(0, 512)) - 256) << $urandom_range(0, 8);
                for (int i = 0; i < 4; i++) begin
                    k0 = $urandom_range(0, 40) - 20;
                    r.c[2*i]   = bx + dx * k0;
                    r.c[2*i+1] = by + dy * k0;
                end
            end
            4: begin
                // first segment collapses to a point, often on the second
                k0 = $urandom_range(0, 4);
                r.c[0] = r.c[4] + (r.c[6] - r.c[4]) / 4 * k0;
                r.c[1] = r.c[5] + (r.c[7] - r.c[5]) / 4 * k0;
                if ($urandom_range(0, 1)) r.c[1] = r.c[1] + 32'($urandom_range(0, 3));
                r.c[2] = r.c[0]; r.c[3] = r.c[1];
            end
            5: begin
                r.c[6] = r.c[4]; r.c[7] = r.c[5];
                if ($urandom_range(0, 1)) begin
                    r.c[4] = r.c[0] + (r.c[2] - r.c[0]) / 2;
                    r.c[5] = r.c[1] + (r.c[3] - r.c[1]) / 2;
                    r.c[6] = r.c[4]; r.c[7] = r.c[5];
                end
            end
            6: begin
                // nearly parallel: second is first shifted by a few LSBs
                k1 = $urandom_range(0, 8) - 4;
                r.c[4] = r.c[0] + 32'(k1); r.c[5] = r.c[1];
                r.c[6] = r.c[2] + 32'(k1); r.c[7] = r.c[3] + 32'($urandom_range(0, 2));
            end
            7: begin
                // share an endpoint
                r.c[4] = r.c[2]; r.c[5] = r.c[3];
            end
            default: ;
        endcase
        return r;
    endfunction

    t_row directed [] = '{
        '{'{32'd0, 32'd0, 2*ONE, 2*ONE, 32'd0, 2*ONE, 2*ONE, 32'd0}, 1'b1,
          '{1'b1, segi_pkg::KIND_CROSS, ONE, ONE}},
        '{'{32'd0, 32'd0, ONE, 32'd0, 32'd0, ONE, ONE, ONE}, 1'b1,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}},
        '{'{32'd0, 32'd0, 2*ONE, 32'd0, ONE, 32'd0, 3*ONE, 32'd0}, 1'b1,
          '{1'b1, segi_pkg::KIND_OVERLAP, ONE, 32'd0}},
        '{'{32'd0, 32'd0, ONE, 32'd0, 2*ONE, 32'd0, 3*ONE, 32'd0}, 1'b1,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}},
        '{'{ONE, ONE, ONE, ONE, 32'd0, 32'd0, 2*ONE, 2*ONE}, 1'b1,
          '{1'b1, segi_pkg::KIND_POINT, ONE, ONE}},
        '{'{ONE, 2*ONE, ONE, 2*ONE, 32'd0, 32'd0, 2*ONE, 2*ONE}, 1'b1,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}},
        '{'{32'd0, 32'd0, 32'd0, 4*ONE, 32'd0, ONE, 32'd0, ONE}, 1'b1,
          '{1'b1, segi_pkg::KIND_POINT, 32'd0, ONE}},
        '{'{ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE}, 1'b1,
          '{1'b1, segi_pkg::KIND_POINT, ONE, ONE}},
        '{'{ONE, ONE, ONE, ONE, 32'd0, ONE, 32'd0, ONE}, 1'b1,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}},
        '{'{32'd0, 32'd0, 2*ONE, 32'd0, 2*ONE, 32'd0, 2*ONE, 2*ONE}, 1'b1,
          '{1'b1, segi_pkg::KIND_CROSS, 2*ONE, 32'd0}},
        '{'{32'd0, 32'd0, 3*ONE, ONE, 32'd0, ONE, ONE, 32'd0}, 1'b0,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}},
        '{'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, 1'b0,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}},
        '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}},
        '{'{32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0,
            32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0}, 1'b0,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}},
        '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001,
            32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF}, 1'b0,
          '{1'b0, segi_pkg::KIND_NONE, 32'd0, 32'd0}}
    };

    // stimulus
    initial begin
        logic [15:0] tols [4];
        t_row        r;
        int          burst;
        tols = '{16'd512, 16'd0, 16'hFFFF, 16'd0};
        tols[3] = 16'($urandom_range(1, 65534));
        tol = t_wide'(segi_pkg::TOL_RESET);
        s_tvalid = 1'b0;
        s_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed[i]) send_request(directed[i].c, directed[i].checked,
                                           directed[i].res);
        for (int ph = 0; ph < 4; ph++) begin
            if (ph != 0) begin
                s_tvalid <= 1'b0;
                write_tolerance(tols[ph]);
            end
            for (int n = 0; n < 370; ) begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst && n < 370; k++, n++) begin
                    r = random_row();
                    send_request(r.c, 1'b0, r.res);
                end
                if ($urandom_range(0, 3) != 0) idle_sender();
            end
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stall pattern, one long hold-off early in the run
    initial begin
        int mode;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        while (1) begin
            @(negedge i_clk);
            if (results_seen == 100) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                m_tready <= 1'b1;
                @(negedge i_clk);
            end
            mode = (cycles / 500) % 3;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_meet want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_meets.size() == 0) begin
                report("unexpected result", m_tdata, 64'd0);
            end else begin
                want = pending_meets.pop_front();
                if (m_tuser[0] !== want.hit)
                    report("hit", 64'(m_tuser[0]), 64'(want.hit));
                if (m_tuser[2:1] !== want.kind)
                    report("kind", 64'(m_tuser[2:1]), 64'(want.kind));
                if (m_tdata[31:0] !== want.x)
                    report("meet_x", 64'(m_tdata[31:0]), 64'(want.x));
                if (m_tdata[63:32] !== want.y)
                    report("meet_y", 64'(m_tdata[63:32]), 64'(want.y));
            end
            results_seen++;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        results_seen = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // drain and finish
    initial begin
        wait (stim_done === 1'b1);
        while (pending_meets.size() != 0) @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);
        if (pending_meets.size() != 0) begin
            $display("%0d results never arrived", pending_meets.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/segi_pkg.sv
hw/rtl/segi_front.sv
hw/rtl/segi_div.sv
hw/rtl/segment_intersection.sv
hw/rtl/segi_checker.sv
dv/segment_intersection_test.sv
